// ===== sv/dmrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the control store of the desk motor ramp controller.
// No dependencies; the interfaces and the top level use it by scoped names.
package dmrc_pkg;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALL_ENABLE   = 3'd0,
        CFG_MOTOR_DISABLE = 3'd1,
        CFG_FULL_SPEED    = 3'd2,
        CFG_STALL_TIMEOUT = 3'd3,
        CFG_CHECK_INTERVAL = 3'd4
    } cfg_idx_t;

    localparam logic [7:0]  FULL_SPEED_RST     = 8'd175;
    localparam logic [15:0] STALL_TIMEOUT_RST  = 16'd250;
    localparam logic [15:0] CHECK_INTERVAL_RST = 16'd100;

    // Ramp lengths in ms
    localparam logic [31:0] MOVE_RAMP_MS   = 32'd1000;
    localparam logic [31:0] SETTLE_RAMP_MS = 32'd500;
    localparam logic [8:0]  SETTLE_SPAN    = 9'd500;

    // ceil(2^28/1000) == ceil(2^27/500): floor(p/1000) = (p*K)>>28, floor(p/500) = (p*K)>>27
    localparam logic [18:0] RECIP_K = 19'd268436;

    // Micro-operations driving the datapath
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CHECK,
        OP_SET_START,
        OP_SETTLE_ES,
        OP_ELAPSED,
        OP_MUL_FE,
        OP_MUL_K,
        OP_RAMP,
        OP_MUL_RS,
        OP_SETTLE_OUT,
        OP_DRV_SETUP,
        OP_DRV_OUT,
        OP_STOP_ZERO,
        OP_LOCK_STOP,
        OP_STOP,
        OP_POST,
        OP_LIMIT,
        OP_HALL_STEP,
        OP_STALL,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_DUE,
        C_BOTH,
        C_RETZERO,
        C_DRIVE_REQ,
        C_NO_SETTLE,
        C_DISABLED,
        C_ES_SAT,
        C_NO_HALL,
        C_OUT_BUSY
    } cond_t;

    typedef logic [4:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Entry points of the program
    localparam step_t STEP_IDLE       = 5'd0;
    localparam step_t STEP_SETTLE_OUT = 5'd14;
    localparam step_t STEP_SETTLE     = 5'd5;
    localparam step_t STEP_DRIVE      = 5'd15;
    localparam step_t STEP_BOTH       = 5'd22;
    localparam step_t STEP_RETZERO    = 5'd23;
    localparam step_t STEP_STOP       = 5'd24;
    localparam step_t STEP_POST       = 5'd25;
    localparam step_t STEP_LIMIT      = 5'd26;
    localparam step_t STEP_EMIT       = 5'd29;
    localparam step_t PROG_LEN        = 5'd31;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            5'd0:  w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,   target: STEP_IDLE};
            5'd1:  w = '{op: OP_CHECK,      cond: C_NOT_DUE,   target: STEP_LIMIT};
            5'd2:  w = '{op: OP_NOP,        cond: C_BOTH,      target: STEP_BOTH};
            5'd3:  w = '{op: OP_NOP,        cond: C_RETZERO,   target: STEP_RETZERO};
            5'd4:  w = '{op: OP_NOP,        cond: C_DRIVE_REQ, target: STEP_DRIVE};
            5'd5:  w = '{op: OP_NOP,        cond: C_NO_SETTLE, target: STEP_STOP};
            5'd6:  w = '{op: OP_SET_START,  cond: C_NEVER,     target: STEP_IDLE};
            5'd7:  w = '{op: OP_SETTLE_ES,  cond: C_NEVER,     target: STEP_IDLE};
            5'd8:  w = '{op: OP_ELAPSED,    cond: C_ES_SAT,    target: STEP_SETTLE_OUT};
            5'd9:  w = '{op: OP_MUL_FE,     cond: C_NEVER,     target: STEP_IDLE};
            5'd10: w = '{op: OP_MUL_K,      cond: C_NEVER,     target: STEP_IDLE};
            5'd11: w = '{op: OP_RAMP,       cond: C_NEVER,     target: STEP_IDLE};
            5'd12: w = '{op: OP_MUL_RS,     cond: C_NEVER,     target: STEP_IDLE};
            5'd13: w = '{op: OP_MUL_K,      cond: C_NEVER,     target: STEP_IDLE};
            5'd14: w = '{op: OP_SETTLE_OUT, cond: C_ALWAYS,    target: STEP_POST};
            5'd15: w = '{op: OP_NOP,        cond: C_DISABLED,  target: STEP_POST};
            5'd16: w = '{op: OP_DRV_SETUP,  cond: C_NEVER,     target: STEP_IDLE};
            5'd17: w = '{op: OP_ELAPSED,    cond: C_NEVER,     target: STEP_IDLE};
            5'd18: w = '{op: OP_MUL_FE,     cond: C_NEVER,     target: STEP_IDLE};
            5'd19: w = '{op: OP_MUL_K,      cond: C_NEVER,     target: STEP_IDLE};
            5'd20: w = '{op: OP_RAMP,       cond: C_NEVER,     target: STEP_IDLE};
            5'd21: w = '{op: OP_DRV_OUT,    cond: C_ALWAYS,    target: STEP_POST};
            5'd22: w = '{op: OP_STOP_ZERO,  cond: C_ALWAYS,    target: STEP_POST};
            5'd23: w = '{op: OP_LOCK_STOP,  cond: C_ALWAYS,    target: STEP_POST};
            5'd24: w = '{op: OP_STOP,       cond: C_NEVER,     target: STEP_IDLE};
            5'd25: w = '{op: OP_POST,       cond: C_NEVER,     target: STEP_IDLE};
            5'd26: w = '{op: OP_LIMIT,      cond: C_NO_HALL,   target: STEP_EMIT};
            5'd27: w = '{op: OP_HALL_STEP,  cond: C_NEVER,     target: STEP_IDLE};
            5'd28: w = '{op: OP_STALL,      cond: C_NEVER,     target: STEP_IDLE};
            5'd29: w = '{op: OP_EMIT,       cond: C_OUT_BUSY,  target: STEP_EMIT};
            5'd30: w = '{op: OP_NOP,        cond: C_ALWAYS,    target: STEP_IDLE};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/dmrc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the desk motor ramp controller: tick input, status output
// and configuration writes. Depends on dmrc_pkg for the configuration widths.

interface dmrc_tick_if;
    logic valid;
    logic ready;
    logic up_button_low;
    logic down_button_low;
    logic limit_level;
    logic hall_level;

    modport source (output valid, output up_button_low, output down_button_low,
                    output limit_level, output hall_level, input ready);
    modport sink   (input valid, input up_button_low, input down_button_low,
                    input limit_level, input hall_level, output ready);
endinterface

interface dmrc_status_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] motor_speed;
    logic              motor_enable;
    logic [7:0]        desk_position;
    logic              is_moving;
    logic              going_up;
    logic              down_locked;
    logic              store_request;

    modport source (output valid, output motor_speed, output motor_enable,
                    output desk_position, output is_moving, output going_up,
                    output down_locked, output store_request, input ready);
    modport sink   (input valid, input motor_speed, input motor_enable,
                    input desk_position, input is_moving, input going_up,
                    input down_locked, input store_request, output ready);
endinterface

interface dmrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmrc_pkg::CFG_IDX_W-1:0]  index;
    logic [dmrc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/desk_motor_ramp_controller.sv =====
`timescale 1ns / 1ps
// Desk motor ramp controller: microcoded sequencer over a small datapath with one
// shared multiplier. Depends on dmrc_pkg and the channel interfaces in dmrc_if.sv.
//
//  channel  | role | word carried                                      | accepted when
//  ---------+------+---------------------------------------------------+---------------
//  tick     | sink | button levels, limit level, hall level (1 ms)     | valid & ready
//  status   | src  | speed, enable, position, moving, dir, lock, store | valid & ready
//  cfg      | sink | register index, write data                        | valid & ready
//
// The program path taken for a tick sets how long it holds the sequencer until the next
// acceptance and when its status word goes valid, the longest being a settle step with
// four passes through the shared multiplier (two for the ramp, two for the settle scale).
// tick.ready is high only while the sequencer sits at its idle step; the status
// word waits in its own register, so the next tick is taken while it is pending.
// A stalled status channel holds the sequencer at its emit step. cfg is always ready.
// rst_n clears the control state asynchronously, but not the tick latch, the arithmetic
// scratch or the status data registers; no clearing pass is needed.

module desk_motor_ramp_controller (
    input  logic           clk,
    input  logic           rst_n,
    dmrc_tick_if.sink      tick,
    dmrc_status_if.source  status,
    dmrc_cfg_if.sink       cfg
);

    // Configuration registers
    logic        hall_enable_reg;
    logic        motor_disable_reg;
    logic [7:0]  full_speed_reg;
    logic [15:0] stall_timeout_reg;
    logic [15:0] check_interval_reg;

    // Controller state
    logic [31:0]       now_reg;
    logic [31:0]       last_check_reg;
    logic [31:0]       move_start_reg;
    logic [31:0]       settle_start_reg;
    logic [31:0]       stall_deadline_reg;
    logic              moving_reg;
    logic              direction_up_reg;
    logic [7:0]        position_reg;
    logic [7:0]        prev_position_reg;
    logic              lockout_reg;
    logic              prev_hall_reg;
    logic signed [8:0] held_speed_reg;
    logic              held_enable_reg;
    logic              store_reg;
    logic              was_moving_reg;

    // Latched tick word
    logic up_low_reg;
    logic down_low_reg;
    logic limit_reg;
    logic hall_reg;

    // Arithmetic scratch
    logic [9:0]  e_lo_reg;
    logic        e_sat_reg;
    logic [8:0]  es_lo_reg;
    logic        es_sat_reg;
    logic [7:0]  ramp_reg;
    logic [36:0] prod_reg;

    // Sequencer
    dmrc_pkg::step_t  step_reg;
    dmrc_pkg::step_t  step_next;
    dmrc_pkg::ucode_t uc;

    // Status output register
    logic              out_valid_reg;
    logic signed [8:0] out_speed_reg;
    logic              out_enable_reg;
    logic [7:0]        out_position_reg;
    logic              out_moving_reg;
    logic              out_up_reg;
    logic              out_locked_reg;
    logic              out_store_reg;

    // Combinational helpers
    logic        up_pressed;
    logic        down_pressed;
    logic [31:0] check_diff;
    logic        due;
    logic [31:0] e_diff;
    logic [31:0] es_diff;
    logic [17:0] mul_a;
    logic [18:0] mul_b;
    logic [36:0] mul_p;
    logic [7:0]  settle_s;
    logic        out_busy;
    logic        cond_true;

    assign up_pressed   = !up_low_reg;
    assign down_pressed = !down_low_reg;
    assign check_diff   = now_reg - last_check_reg;
    assign due          = check_diff > {16'd0, check_interval_reg};
    assign e_diff       = now_reg - move_start_reg;
    assign es_diff      = now_reg - settle_start_reg;
    assign settle_s     = prod_reg[34:27];
    assign out_busy     = out_valid_reg && !status.ready;

    // Fetch the control word
    assign uc = dmrc_pkg::ucode_rom(step_reg);

    assign tick.ready = (uc.op == dmrc_pkg::OP_ACCEPT);
    assign cfg.ready  = 1'b1;

    // Evaluate the jump condition
    always_comb
    begin
        case (uc.cond)
            dmrc_pkg::C_NEVER:     cond_true = 1'b0;
            dmrc_pkg::C_ALWAYS:    cond_true = 1'b1;
            dmrc_pkg::C_NO_ITEM:   cond_true = !tick.valid;
            dmrc_pkg::C_NOT_DUE:   cond_true = !due;
            dmrc_pkg::C_BOTH:      cond_true = up_pressed && down_pressed;
            dmrc_pkg::C_RETZERO:   cond_true = (prev_position_reg != position_reg)
                                               && (position_reg == 8'd0);
            dmrc_pkg::C_DRIVE_REQ: cond_true = up_pressed || (down_pressed && !lockout_reg);
            dmrc_pkg::C_NO_SETTLE: cond_true = motor_disable_reg || !moving_reg;
            dmrc_pkg::C_DISABLED:  cond_true = motor_disable_reg;
            dmrc_pkg::C_ES_SAT:    cond_true = es_sat_reg;
            dmrc_pkg::C_NO_HALL:   cond_true = !hall_enable_reg;
            dmrc_pkg::C_OUT_BUSY:  cond_true = out_busy;
            default:               cond_true = 1'b0;
        endcase
        step_next = cond_true ? uc.target : step_reg + 5'd1;
    end

    // Route operands to the shared multiplier
    always_comb
    begin
        case (uc.op)
            dmrc_pkg::OP_MUL_FE:
            begin
                mul_a = {10'd0, full_speed_reg};
                mul_b = {9'd0, e_lo_reg};
            end
            dmrc_pkg::OP_MUL_RS:
            begin
                mul_a = {10'd0, ramp_reg};
                mul_b = {10'd0, dmrc_pkg::SETTLE_SPAN - es_lo_reg};
            end
            default:
            begin
                mul_a = prod_reg[17:0];
                mul_b = dmrc_pkg::RECIP_K;
            end
        endcase
        mul_p = 37'(mul_a) * 37'(mul_b);
    end

    // Sequencer, datapath and status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg           <= dmrc_pkg::STEP_IDLE;
            hall_enable_reg    <= 1'b0;
            motor_disable_reg  <= 1'b0;
            full_speed_reg     <= dmrc_pkg::FULL_SPEED_RST;
            stall_timeout_reg  <= dmrc_pkg::STALL_TIMEOUT_RST;
            check_interval_reg <= dmrc_pkg::CHECK_INTERVAL_RST;
            now_reg            <= '0;
            last_check_reg     <= '0;
            move_start_reg     <= '0;
            settle_start_reg   <= '0;
            stall_deadline_reg <= '0;
            moving_reg         <= 1'b0;
            direction_up_reg   <= 1'b1;
            position_reg       <= '0;
            prev_position_reg  <= '0;
            lockout_reg        <= 1'b0;
            prev_hall_reg      <= 1'b1;
            held_speed_reg     <= '0;
            held_enable_reg    <= 1'b0;
            store_reg          <= 1'b0;
            was_moving_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            // Take configuration writes
            if (cfg.valid)
            begin
                case (cfg.index)
                    dmrc_pkg::CFG_HALL_ENABLE:    hall_enable_reg    <= cfg.data[0];
                    dmrc_pkg::CFG_MOTOR_DISABLE:  motor_disable_reg  <= cfg.data[0];
                    dmrc_pkg::CFG_FULL_SPEED:     full_speed_reg     <= cfg.data[7:0];
                    dmrc_pkg::CFG_STALL_TIMEOUT:  stall_timeout_reg  <= cfg.data;
                    dmrc_pkg::CFG_CHECK_INTERVAL: check_interval_reg <= cfg.data;
                    default: ;
                endcase
            end

            // Drop the status word once taken, unless the emit step refills it
            if (out_valid_reg && status.ready && (uc.op != dmrc_pkg::OP_EMIT))
                out_valid_reg <= 1'b0;

            // Execute the micro-operation
            case (uc.op)
                dmrc_pkg::OP_ACCEPT:
                begin
                    if (tick.valid)
                    begin
                        up_low_reg   <= tick.up_button_low;
                        down_low_reg <= tick.down_button_low;
                        limit_reg    <= tick.limit_level;
                        hall_reg     <= tick.hall_level;
                        now_reg      <= now_reg + 32'd1;
                        store_reg    <= 1'b0;
                    end
                end
                dmrc_pkg::OP_CHECK:
                begin
                    if (due)
                    begin
                        last_check_reg <= now_reg;
                        was_moving_reg <= moving_reg;
                    end
                end
                dmrc_pkg::OP_SET_START:
                begin
                    if (settle_start_reg == 32'd0)
                        settle_start_reg <= now_reg;
                end
                dmrc_pkg::OP_SETTLE_ES:
                begin
                    es_lo_reg  <= es_diff[8:0];
                    es_sat_reg <= es_diff >= dmrc_pkg::SETTLE_RAMP_MS;
                end
                dmrc_pkg::OP_ELAPSED:
                begin
                    e_lo_reg  <= e_diff[9:0];
                    e_sat_reg <= e_diff >= dmrc_pkg::MOVE_RAMP_MS;
                end
                dmrc_pkg::OP_MUL_FE, dmrc_pkg::OP_MUL_K, dmrc_pkg::OP_MUL_RS:
                begin
                    prod_reg <= mul_p;
                end
                dmrc_pkg::OP_RAMP:
                begin
                    ramp_reg <= e_sat_reg ? full_speed_reg : prod_reg[35:28];
                end
                dmrc_pkg::OP_SETTLE_OUT:
                begin
                    if (es_sat_reg || settle_s == 8'd0)
                    begin
                        settle_start_reg <= '0;
                        move_start_reg   <= '0;
                        moving_reg       <= 1'b0;
                        held_speed_reg   <= '0;
                        held_enable_reg  <= 1'b0;
                    end
                    else
                    begin
                        held_enable_reg <= 1'b1;
                        held_speed_reg  <= direction_up_reg ? $signed({1'b0, settle_s})
                                                            : -$signed({1'b0, settle_s});
                    end
                end
                dmrc_pkg::OP_DRV_SETUP:
                begin
                    if (!moving_reg)
                        stall_deadline_reg <= now_reg + {16'd0, stall_timeout_reg};
                    if (move_start_reg == 32'd0)
                        move_start_reg <= now_reg;
                end
                dmrc_pkg::OP_DRV_OUT:
                begin
                    held_enable_reg  <= 1'b1;
                    held_speed_reg   <= up_pressed ? $signed({1'b0, ramp_reg})
                                                   : -$signed({1'b0, ramp_reg});
                    moving_reg       <= 1'b1;
                    direction_up_reg <= up_pressed;
                end
                dmrc_pkg::OP_STOP_ZERO:
                begin
                    move_start_reg  <= '0;
                    moving_reg      <= 1'b0;
                    held_speed_reg  <= '0;
                    held_enable_reg <= 1'b0;
                    position_reg    <= '0;
                    if (hall_enable_reg)
                        store_reg <= 1'b1;
                end
                dmrc_pkg::OP_LOCK_STOP:
                begin
                    lockout_reg     <= 1'b1;
                    move_start_reg  <= '0;
                    moving_reg      <= 1'b0;
                    held_speed_reg  <= '0;
                    held_enable_reg <= 1'b0;
                end
                dmrc_pkg::OP_STOP:
                begin
                    move_start_reg  <= '0;
                    moving_reg      <= 1'b0;
                    held_speed_reg  <= '0;
                    held_enable_reg <= 1'b0;
                end
                dmrc_pkg::OP_POST:
                begin
                    if (was_moving_reg && !moving_reg && hall_enable_reg)
                        store_reg <= 1'b1;
                end
                dmrc_pkg::OP_LIMIT:
                begin
                    if (!limit_reg && !direction_up_reg && moving_reg)
                    begin
                        position_reg    <= '0;
                        if (hall_enable_reg)
                            store_reg <= 1'b1;
                        move_start_reg  <= '0;
                        moving_reg      <= 1'b0;
                        held_speed_reg  <= '0;
                        held_enable_reg <= 1'b0;
                        lockout_reg     <= 1'b1;
                    end
                    else
                        lockout_reg <= 1'b0;
                end
                dmrc_pkg::OP_HALL_STEP:
                begin
                    prev_position_reg <= position_reg;
                    if (prev_hall_reg && !hall_reg)
                        position_reg <= direction_up_reg ? position_reg + 8'd1
                                                         : position_reg - 8'd1;
                    if (prev_hall_reg != hall_reg)
                    begin
                        prev_hall_reg      <= hall_reg;
                        stall_deadline_reg <= now_reg + {16'd0, stall_timeout_reg};
                    end
                end
                dmrc_pkg::OP_STALL:
                begin
                    if (moving_reg && now_reg > stall_deadline_reg)
                    begin
                        position_reg    <= '0;
                        store_reg       <= 1'b1;
                        move_start_reg  <= '0;
                        moving_reg      <= 1'b0;
                        held_speed_reg  <= '0;
                        held_enable_reg <= 1'b0;
                        lockout_reg     <= 1'b1;
                    end
                end
                dmrc_pkg::OP_EMIT:
                begin
                    if (!out_busy)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_speed_reg    <= held_speed_reg;
                        out_enable_reg   <= held_enable_reg;
                        out_position_reg <= position_reg;
                        out_moving_reg   <= moving_reg;
                        out_up_reg       <= direction_up_reg;
                        out_locked_reg   <= lockout_reg;
                        out_store_reg    <= store_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.motor_speed   = out_speed_reg;
    assign status.motor_enable  = out_enable_reg;
    assign status.desk_position = out_position_reg;
    assign status.is_moving     = out_moving_reg;
    assign status.going_up      = out_up_reg;
    assign status.down_locked   = out_locked_reg;
    assign status.store_request = out_store_reg;

    // The driver is enabled exactly while the motor counts as moving
    a_enable_tracks_moving: assert property (@(posedge clk) disable iff (!rst_n)
        held_enable_reg == moving_reg)
        else $error("held enable differs from moving flag");

    // A disabled driver holds zero speed
    a_stopped_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        !held_enable_reg |-> held_speed_reg == 9'sd0)
        else $error("nonzero speed with driver disabled");

    // The step counter never leaves the program
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < dmrc_pkg::PROG_LEN)
        else $error("step counter outside program");

    // A new status word only comes from the emit step
    a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg) == dmrc_pkg::STEP_EMIT)
        else $error("status word raised outside emit step");

endmodule

// ===== verif/desk_motor_ramp_controller_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for desk_motor_ramp_controller: directed table, then random ticks
// checked word by word against a behavioral prediction of the motor status.
// Depends on dmrc_pkg, the channel interfaces in dmrc_if.sv and the block itself.

module desk_motor_ramp_controller_test;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int STATUS_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 60;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic up_n;
        logic down_n;
        logic limit_n;
        logic hall;
    } tick_word_t;

    typedef struct packed {
        logic signed [8:0] speed;
        logic              enable;
        logic [7:0]        position;
        logic              moving;
        logic              up;
        logic              locked;
        logic              store;
    } status_word_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        tick_word_t         levels;
        dmrc_pkg::cfg_idx_t reg_idx;
        logic [15:0]        reg_data;
        logic               typed;
        status_word_t       want;
    } script_row_t;

    localparam status_word_t IDLE_WORD = '{speed: 9'sd0, enable: 1'b0, position: 8'd0,
                                           moving: 1'b0, up: 1'b1, locked: 1'b0,
                                           store: 1'b0};

    logic clk;
    logic rst_n;

    dmrc_tick_if   tick_bus();
    dmrc_status_if status_bus();
    dmrc_cfg_if    cfg_bus();

    desk_motor_ramp_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_bus),
        .status (status_bus),
        .cfg    (cfg_bus)
    );

    // Free-running clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predicted controller state
    logic [31:0]       clock_ms, decided_ms, ramp_origin_ms, coast_origin_ms, stall_limit_ms;
    logic              running, heading_up, down_blocked, last_hall, drive_on, save_pulse;
    logic [7:0]        position, last_position;
    logic signed [8:0] drive_speed;

    // Predicted register contents
    logic        cfg_hall, cfg_no_drive;
    logic [7:0]  cfg_full;
    logic [15:0] cfg_stall, cfg_interval;

    status_word_t pending_status [$];
    script_row_t  script [$];

    int failures;
    int reports;
    int ticks_sent;
    int words_checked;
    int regs_written;
    int settings_applied;
    int quiet_cycles;
    int gap_pct;
    int status_stall_pct;
    bit status_hold_req;
    bit cfg_held;

    function automatic void reset_prediction();
        clock_ms = 0;
        decided_ms = 0;
        ramp_origin_ms = 0;
        coast_origin_ms = 0;
        stall_limit_ms = 0;
        running = 1'b0;
        heading_up = 1'b1;
        down_blocked = 1'b0;
        last_hall = 1'b1;
        drive_on = 1'b0;
        drive_speed = '0;
        save_pulse = 1'b0;
        position = '0;
        last_position = '0;
        cfg_hall = 1'b0;
        cfg_no_drive = 1'b0;
        cfg_full = dmrc_pkg::FULL_SPEED_RST;
        cfg_stall = dmrc_pkg::STALL_TIMEOUT_RST;
        cfg_interval = dmrc_pkg::CHECK_INTERVAL_RST;
    endfunction

    function automatic void note_register(dmrc_pkg::cfg_idx_t idx, logic [15:0] d);
        case (idx)
            dmrc_pkg::CFG_HALL_ENABLE:    cfg_hall = d[0];
            dmrc_pkg::CFG_MOTOR_DISABLE:  cfg_no_drive = d[0];
            dmrc_pkg::CFG_FULL_SPEED:     cfg_full = d[7:0];
            dmrc_pkg::CFG_STALL_TIMEOUT:  cfg_stall = d;
            dmrc_pkg::CFG_CHECK_INTERVAL: cfg_interval = d;
            default: ;
        endcase
    endfunction

    // Linear ramp from the move start, full speed after MOVE_RAMP_MS
    function automatic logic [31:0] ramp_target();
        logic [31:0] e;
        e = clock_ms - ramp_origin_ms;
        if (e >= dmrc_pkg::MOVE_RAMP_MS)
            return {24'd0, cfg_full};
        return ({24'd0, cfg_full} * e) / dmrc_pkg::MOVE_RAMP_MS;
    endfunction

    // Ramp speed scaled down to zero over SETTLE_RAMP_MS
    function automatic logic [31:0] coast_target();
        logic [31:0] es;
        es = clock_ms - coast_origin_ms;
        if (es >= dmrc_pkg::SETTLE_RAMP_MS)
            return 32'd0;
        return (ramp_target() * (dmrc_pkg::SETTLE_RAMP_MS - es)) / dmrc_pkg::SETTLE_RAMP_MS;
    endfunction

    function automatic void mark_store();
        if (cfg_hall)
            save_pulse = 1'b1;
    endfunction

    function automatic void clear_position();
        position = '0;
        mark_store();
    endfunction

    function automatic void halt_motor();
        ramp_origin_ms = 0;
        running = 1'b0;
        drive_speed = '0;
        drive_on = 1'b0;
    endfunction

    function automatic void hold_speed(logic up, logic [31:0] s);
        drive_on = 1'b1;
        drive_speed = up ? 9'(int'(s)) : 9'(-int'(s));
    endfunction

    function automatic void drive_motor(logic up);
        if (cfg_no_drive)
            return;
        if (!running)
            stall_limit_ms = clock_ms + cfg_stall;
        if (ramp_origin_ms == 0)
            ramp_origin_ms = clock_ms;
        hold_speed(up, ramp_target());
        running = 1'b1;
        heading_up = up;
    endfunction

    function automatic void coast();
        logic [31:0] s;
        if (cfg_no_drive || !running)
        begin
            halt_motor();
            return;
        end
        if (coast_origin_ms == 0)
            coast_origin_ms = clock_ms;
        s = coast_target();
        if (s == 0)
        begin
            coast_origin_ms = 0;
            halt_motor();
        end
        else
            hold_speed(heading_up, s);
    endfunction

    // Advance the prediction by one 1 ms tick and return the status word it yields
    function automatic status_word_t next_status_word(tick_word_t lv);
        logic up_p, dn_p, trip, was_running;
        status_word_t w;
        up_p = !lv.up_n;
        dn_p = !lv.down_n;
        trip = !lv.limit_n;
        save_pulse = 1'b0;
        clock_ms = clock_ms + 1;

        // button decision, once per check interval
        if (clock_ms - decided_ms > {16'd0, cfg_interval})
        begin
            was_running = running;
            decided_ms = clock_ms;
            if (up_p && dn_p)
            begin
                halt_motor();
                clear_position();
            end
            else if (last_position != position && position == 0)
            begin
                down_blocked = 1'b1;
                halt_motor();
            end
            else if (up_p)
                drive_motor(1'b1);
            else if (!down_blocked && dn_p)
                drive_motor(1'b0);
            else
                coast();
            if (was_running && !running)
                mark_store();
        end

        // lower limit while moving down
        if (trip && !heading_up && running)
        begin
            clear_position();
            halt_motor();
            down_blocked = 1'b1;
        end
        else
            down_blocked = 1'b0;

        // hall edge counting and stall stop
        if (cfg_hall)
        begin
            last_position = position;
            if (last_hall && !lv.hall)
                position = heading_up ? position + 8'd1 : position - 8'd1;
            if (last_hall != lv.hall)
            begin
                last_hall = lv.hall;
                stall_limit_ms = clock_ms + cfg_stall;
            end
            if (running && clock_ms > stall_limit_ms)
            begin
                clear_position();
                halt_motor();
                down_blocked = 1'b1;
            end
        end

        w.speed = drive_speed;
        w.enable = drive_on;
        w.position = position;
        w.moving = running;
        w.up = heading_up;
        w.locked = down_blocked;
        w.store = save_pulse;
        return w;
    endfunction

    task automatic release_cfg();
        if (cfg_held)
        begin
            cfg_bus.valid <= 1'b0;
            cfg_held = 1'b0;
        end
    endtask

    // Offer one tick word, wait for it to be taken, queue its expected status
    task automatic send_tick(tick_word_t lv, logic typed, status_word_t want);
        status_word_t w;
        release_cfg();
        while ($urandom_range(99) < gap_pct)
        begin
            tick_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tick_bus.valid <= 1'b1;
        tick_bus.up_button_low <= lv.up_n;
        tick_bus.down_button_low <= lv.down_n;
        tick_bus.limit_level <= lv.limit_n;
        tick_bus.hall_level <= lv.hall;
        do
            @(posedge clk);
        while (!tick_bus.ready);
        w = next_status_word(lv);
        pending_status.push_back(typed ? want : w);
        ticks_sent++;
    endtask

    // Hold off new ticks until every status word is back and the block is idle
    task automatic wait_drained();
        tick_bus.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(dmrc_pkg::cfg_idx_t idx, logic [15:0] d);
        cfg_bus.index <= idx;
        cfg_bus.data <= d;
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_held = 1'b1;
        note_register(idx, d);
        regs_written++;
    endtask

    task automatic apply_settings(logic hall, logic no_drive, logic [7:0] full,
                                  logic [15:0] stall, logic [15:0] interval);
        wait_drained();
        write_reg(dmrc_pkg::CFG_HALL_ENABLE, {15'd0, hall});
        write_reg(dmrc_pkg::CFG_MOTOR_DISABLE, {15'd0, no_drive});
        write_reg(dmrc_pkg::CFG_FULL_SPEED, {8'd0, full});
        write_reg(dmrc_pkg::CFG_STALL_TIMEOUT, stall);
        write_reg(dmrc_pkg::CFG_CHECK_INTERVAL, interval);
        settings_applied++;
    endtask

    // Random button sessions: held presses, toggling hall, occasional limit trips and noise
    task automatic run_session(int count, int max_hold, int hall_span, int trip_pct);
        int sent, mode, len, hall_wait;
        logic hall_state;
        tick_word_t lv;
        sent = 0;
        hall_wait = 1;
        hall_state = 1'b1;
        while (sent < count)
        begin
            mode = $urandom_range(99);
            len = $urandom_range(1, max_hold);
            for (int i = 0; i < len && sent < count; i++)
            begin
                hall_wait--;
                if (hall_wait <= 0)
                begin
                    hall_state = ~hall_state;
                    hall_wait = $urandom_range(1, hall_span);
                end
                lv.up_n = !(mode < 30 || (mode >= 78 && mode < 86));
                lv.down_n = !((mode >= 30 && mode < 60) || (mode >= 78 && mode < 86));
                lv.limit_n = !(mode >= 30 && mode < 60 && $urandom_range(99) < trip_pct);
                lv.hall = hall_state;
                if (mode >= 86)
                    lv = 4'($urandom);
                send_tick(lv, 1'b0, IDLE_WORD);
                sent++;
            end
        end
    endtask

    task automatic compare_field(string field, int want, int got);
        if (want != got)
        begin
            failures++;
            if (reports < MAX_REPORTS)
                $display("%0t: status word %0d field %s expected %0d, actual %0d",
                         $time, words_checked, field, want, got);
            else if (reports == MAX_REPORTS)
                $display("%0t: further mismatch reports suppressed", $time);
            reports++;
        end
    endtask

    // Check each status word against the oldest expectation
    always @(posedge clk)
    begin
        status_word_t exp_word;
        if (rst_n && status_bus.valid && status_bus.ready)
        begin
            if (pending_status.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected status word, expected none, actual speed %0d pos %0d",
                         $time, status_bus.motor_speed, status_bus.desk_position);
            end
            else
            begin
                exp_word = pending_status.pop_front();
                compare_field("motor_speed", int'(exp_word.speed), int'(status_bus.motor_speed));
                compare_field("motor_enable", exp_word.enable, status_bus.motor_enable);
                compare_field("desk_position", exp_word.position, status_bus.desk_position);
                compare_field("is_moving", exp_word.moving, status_bus.is_moving);
                compare_field("going_up", exp_word.up, status_bus.going_up);
                compare_field("down_locked", exp_word.locked, status_bus.down_locked);
                compare_field("store_request", exp_word.store, status_bus.store_request);
            end
            words_checked++;
        end
    end

    // Drive status ready: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        status_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (status_hold_req)
            begin
                hold_left = STATUS_HOLD_CYCLES;
                status_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                status_bus.ready <= 1'b0;
            end
            else
                status_bus.ready <= ($urandom_range(99) >= status_stall_pct);
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (tick_bus.valid && tick_bus.ready) ||
            (status_bus.valid && status_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d status words outstanding",
                         $time, quiet_cycles, pending_status.size());
                $display("desk_motor_ramp_controller regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        failures = 0;
        reports = 0;
        ticks_sent = 0;
        words_checked = 0;
        regs_written = 0;
        settings_applied = 0;
        quiet_cycles = 0;
        status_hold_req = 1'b0;
        cfg_held = 1'b0;
        gap_pct = 12;
        status_stall_pct = 54;
        reset_prediction();

        rst_n <= 1'b0;
        tick_bus.valid <= 1'b0;
        tick_bus.up_button_low <= 1'b1;
        tick_bus.down_button_low <= 1'b1;
        tick_bus.limit_level <= 1'b1;
        tick_bus.hall_level <= 1'b1;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= dmrc_pkg::CFG_HALL_ENABLE;
        cfg_bus.data <= '0;

        // Directed table: levels are {up_n, down_n, limit_n, hall}
        script = '{
            // reset settings, no decision due yet: idle status
            '{ROW_TICK,  4'b1111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b1, IDLE_WORD},
            '{ROW_TICK,  4'b0010, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b1, IDLE_WORD},
            '{ROW_TICK,  4'b1101, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b1, IDLE_WORD},
            // hall mode, full speed extreme, decision every tick
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_HALL_ENABLE,    16'd1,    1'b0, IDLE_WORD},
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_FULL_SPEED,     16'd255,  1'b0, IDLE_WORD},
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_STALL_TIMEOUT,  16'hFFFF, 1'b0, IDLE_WORD},
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_CHECK_INTERVAL, 16'd0,    1'b0, IDLE_WORD},
            // drive up, count a hall step, then down back to zero and lock out
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0110, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1010, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1011, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            // down through zero wraps the count, then the limit trips
            '{ROW_TICK,  4'b1010, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1011, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1001, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1011, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            // up, release to settle, both pressed
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0011, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            // motor disabled: presses do nothing
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_MOTOR_DISABLE,  16'd1,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b1011, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            // stall timeout of 1: moving without hall change stops
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_MOTOR_DISABLE,  16'd0,    1'b0, IDLE_WORD},
            '{ROW_WRITE, 4'b1111, dmrc_pkg::CFG_STALL_TIMEOUT,  16'd1,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0111, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD},
            '{ROW_TICK,  4'b0110, dmrc_pkg::CFG_HALL_ENABLE,    16'd0,    1'b0, IDLE_WORD}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(script[i].reg_idx, script[i].reg_data);
            end
            else
                send_tick(script[i].levels, script[i].typed, script[i].want);
        end

        // Random sessions; sender idles lightly, status side heavily
        apply_settings(1'b1, 1'b0, 8'd175, 16'd250, 16'd100);
        run_session(300, 400, 30, 2);
        apply_settings(1'b1, 1'b0, 8'd255, 16'd30, 16'd5);
        run_session(400, 120, 20, 3);

        // Swap idling; hold the status side off long enough to back up the ticks
        gap_pct = 54;
        status_stall_pct = 12;
        apply_settings(1'b0, 1'b0, 8'd0, 16'd1, 16'd1);
        status_hold_req = 1'b1;
        run_session(200, 40, 8, 5);
        apply_settings(1'b1, 1'b1, 8'd128, 16'd100, 16'd2);
        run_session(150, 40, 10, 5);
        apply_settings(1'b1, 1'b0, 8'd255, 16'd1, 16'd0);
        run_session(250, 30, 2, 4);

        // No idling on either side
        gap_pct = 0;
        status_stall_pct = 0;
        apply_settings(1'b1, 1'b0, 8'd255, 16'hFFFF, 16'd7);
        run_session(450, 1100, 15, 0);
        apply_settings(1'b1, 1'b0, 8'd200, 16'd250, 16'hFFFF);
        run_session(100, 50, 5, 10);

        // Drain and let the block go quiet
        wait_drained();
        release_cfg();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ticks under %0d register settings (%0d writes), %0d status words",
                 ticks_sent, settings_applied, regs_written, words_checked);
        $display("checked with %0d field mismatches", failures);
        if (failures == 0)
            $display("desk_motor_ramp_controller regression: pass");
        else
            $display("desk_motor_ramp_controller regression: fail");
        $finish;
    end

endmodule
